// ===== hdl/spl_pkg.sv =====
// Shared constants and types for the stereo peak limiter.
package spl_pkg;

    // Sample, threshold and coefficient formats
    localparam int SAMPLE_W  = 16;
    localparam int THR_W     = 15;
    localparam int COEF_BITS = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    // Coefficient one and rounding half, 16 fractional bits
    localparam logic [COEF_BITS:0] COEF_ONE  = (COEF_BITS+1)'(1) << COEF_BITS;
    localparam logic [COEF_BITS:0] COEF_HALF = (COEF_BITS+1)'(1) << (COEF_BITS - 1);

    // Saturation limits on the magnitude of a scaled sample
    localparam logic [SAMPLE_W:0] SAT_POS_MAG = (SAMPLE_W+1)'(32767);
    localparam logic [SAMPLE_W:0] SAT_NEG_MAG = (SAMPLE_W+1)'(32768);

    // Register reset values
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(32767);

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE  = 2'd0,
        CFG_THRESH  = 2'd1,
        CFG_ATTACK  = 2'd2,
        CFG_RELEASE = 2'd3
    } cfg_idx_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_COEF,
        ST_MUL_T,
        ST_MUL_G,
        ST_ACC,
        ST_MUL_L,
        ST_MUL_R,
        ST_FIN,
        ST_OUT
    } state_t;

endpackage

// ===== hdl/spl_div.sv =====
// Bit-serial restoring divider giving the limiter's target gain.
module spl_div
    import spl_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [THR_W-1:0]     dividend,
    input  logic [SAMPLE_W-1:0]  divisor,
    output logic                 done,
    output logic [FRAC_BITS-1:0] quotient
);

    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    logic [SAMPLE_W-1:0]  rem_reg;
    logic [FRAC_BITS-1:0] quo_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 done_reg;

    logic [SAMPLE_W:0]    trial;
    logic [SAMPLE_W:0]    diff;
    logic                 ge;

    // One quotient bit per cycle; remainder stays below the divisor
    always_comb begin
        trial = {rem_reg, 1'b0};
        ge    = trial >= {1'b0, divisor};
        diff  = trial - {1'b0, divisor};
    end

    // Step counter and completion flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= CNT_W'(FRAC_BITS);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift register
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= SAMPLE_W'(dividend);
            quo_reg <= '0;
        end else if (cnt_reg != '0) begin
            rem_reg <= ge ? diff[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
            quo_reg <= {quo_reg[FRAC_BITS-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hdl/stereo_peak_limiter.sv =====
// Stereo linked peak limiter: sequencer, shared multiplier and gain state.
//
// Takes one stereo pair per input transfer and gives one limited pair per
// output transfer. While enabled and the peak is above the threshold, an
// item first waits on the bit-serial divider that forms threshold/peak,
// and then takes its steps on a single shared 17 x (FRAC_BITS+1)
// multiplier that smooths the gain and scales each channel in turn. When
// the peak is within the threshold the divider is skipped. While disabled
// the pair is copied to the result registers at acceptance and the gain
// is held at unity. Input ready is high only while the sequencer is idle;
// a finished result waits in the output register, so the next pair can
// be taken before it is collected. Writing enable as zero snaps the gain
// back to unity. The user is to write configuration only while no item is
// in progress; the block itself does not enforce this.
module stereo_peak_limiter
    import spl_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // Input channel
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [SAMPLE_W-1:0] s_left_in,
    input  logic signed [SAMPLE_W-1:0] s_right_in,
    // Result channel
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [SAMPLE_W-1:0] m_left_out,
    output logic signed [SAMPLE_W-1:0] m_right_out,
    // Configuration write port
    input  logic                       cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_W-1:0]           cfg_wdata
);

    localparam int GAIN_W = FRAC_BITS + 1;
    localparam int MUL_A_W = COEF_BITS + 1;
    localparam int PROD_W = MUL_A_W + GAIN_W;
    localparam int ACC_W = PROD_W + 1;
    localparam logic [GAIN_W-1:0] UNITY = GAIN_W'(1) << FRAC_BITS;
    localparam logic [PROD_W-1:0] HALF_F = PROD_W'(1) << (FRAC_BITS - 1);

    // Configuration registers
    logic                 enable_reg;
    logic [THR_W-1:0]     thresh_reg;
    logic [COEF_BITS-1:0] attack_reg;
    logic [COEF_BITS-1:0] release_reg;

    // Control state
    state_t               state_reg, state_next;
    logic [GAIN_W-1:0]    gain_reg;
    logic                 m_valid_reg;

    // Datapath registers
    logic [SAMPLE_W-1:0]  left_reg, right_reg;
    logic [SAMPLE_W-1:0]  mag_l_reg, mag_r_reg;
    logic [SAMPLE_W-1:0]  peak_reg;
    logic [GAIN_W-1:0]    target_reg;
    logic [COEF_BITS-1:0] coef_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [ACC_W-1:0]     acc_reg;
    logic [SAMPLE_W-1:0]  res_l_reg, res_r_reg;
    logic [SAMPLE_W-1:0]  m_left_reg, m_right_reg;

    // Combinational signals
    logic                 s_fire;
    logic                 out_load;
    logic                 div_start;
    logic                 div_done;
    logic [FRAC_BITS-1:0] div_q;
    logic                 over_thr;
    logic [SAMPLE_W-1:0]  mag_l_in, mag_r_in;
    logic [MUL_A_W-1:0]   mul_a;
    logic [GAIN_W-1:0]    mul_b;
    logic [ACC_W-1:0]     acc_sum;

    // Magnitude of a two's complement sample; the most negative value maps to 0x8000
    function automatic logic [SAMPLE_W-1:0] mag16(input logic [SAMPLE_W-1:0] x);
        return x[SAMPLE_W-1] ? (~x + SAMPLE_W'(1)) : x;
    endfunction

    // Round half away from zero and saturate a scaled magnitude back to a sample
    function automatic logic [SAMPLE_W-1:0] round_sat(input logic [PROD_W-1:0] p,
                                                      input logic neg);
        logic [PROD_W-1:0]   rnd;
        logic [SAMPLE_W:0]   mag;
        logic [SAMPLE_W:0]   lim;
        logic [SAMPLE_W-1:0] res;
        rnd = p + HALF_F;
        mag = rnd[FRAC_BITS +: SAMPLE_W+1];
        if (neg) begin
            lim = (mag > SAT_NEG_MAG) ? SAT_NEG_MAG : mag;
            res = SAMPLE_W'((SAMPLE_W+1)'(0) - lim);
        end else begin
            lim = (mag > SAT_POS_MAG) ? SAT_POS_MAG : mag;
            res = lim[SAMPLE_W-1:0];
        end
        return res;
    endfunction

    // Threshold divider
    spl_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (thresh_reg),
        .divisor  (peak_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign mag_l_in = mag16(s_left_in);
    assign mag_r_in = mag16(s_right_in);
    assign over_thr = peak_reg > {1'b0, thresh_reg};
    assign acc_sum  = acc_reg + ACC_W'(prod_reg);

    // Next-state logic
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_fire) state_next = enable_reg ? ST_PREP : ST_OUT;
            ST_PREP:  state_next = over_thr ? ST_DIV : ST_COEF;
            ST_DIV:   if (div_done) state_next = ST_COEF;
            ST_COEF:  state_next = ST_MUL_T;
            ST_MUL_T: state_next = ST_MUL_G;
            ST_MUL_G: state_next = ST_ACC;
            ST_ACC:   state_next = ST_MUL_L;
            ST_MUL_L: state_next = ST_MUL_R;
            ST_MUL_R: state_next = ST_FIN;
            ST_FIN:   state_next = ST_OUT;
            ST_OUT:   if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs and shared multiplier operand selection
    always_comb begin
        s_ready   = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        unique case (state_reg)
            ST_IDLE:  s_ready = 1'b1;
            ST_PREP:  div_start = over_thr;
            ST_MUL_T: begin
                mul_a = COEF_ONE - MUL_A_W'(coef_reg);
                mul_b = target_reg;
            end
            ST_MUL_G: begin
                mul_a = MUL_A_W'(coef_reg);
                mul_b = gain_reg;
            end
            ST_MUL_L: begin
                mul_a = MUL_A_W'(mag_l_reg);
                mul_b = gain_reg;
            end
            ST_MUL_R: begin
                mul_a = MUL_A_W'(mag_r_reg);
                mul_b = gain_reg;
            end
            ST_OUT:   out_load = !m_valid_reg || m_ready;
            default: begin
            end
        endcase
    end

    assign s_fire = s_valid && s_ready;

    // Control registers: state, gain, output valid and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            gain_reg    <= UNITY;
            m_valid_reg <= 1'b0;
            enable_reg  <= 1'b0;
            thresh_reg  <= THR_RESET;
            attack_reg  <= '0;
            release_reg <= '0;
        end else begin
            state_reg <= state_next;

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            // Gain: smoothed update, or unity while bypassed
            if (state_reg == ST_ACC) begin
                gain_reg <= acc_sum[COEF_BITS +: GAIN_W];
            end else if (s_fire && !enable_reg) begin
                gain_reg <= UNITY;
            end

            if (cfg_wr_en) begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_ENABLE: begin
                        enable_reg <= cfg_wdata[0];
                        if (!cfg_wdata[0]) gain_reg <= UNITY;
                    end
                    CFG_THRESH:  thresh_reg  <= cfg_wdata[THR_W-1:0];
                    CFG_ATTACK:  attack_reg  <= cfg_wdata[COEF_BITS-1:0];
                    CFG_RELEASE: release_reg <= cfg_wdata[COEF_BITS-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        // Capture the pair and its linked peak
        if (s_fire) begin
            left_reg  <= s_left_in;
            right_reg <= s_right_in;
            mag_l_reg <= mag_l_in;
            mag_r_reg <= mag_r_in;
            peak_reg  <= (mag_r_in > mag_l_in) ? mag_r_in : mag_l_in;
            res_l_reg <= s_left_in;
            res_r_reg <= s_right_in;
        end

        // Target gain
        if (state_reg == ST_PREP) begin
            target_reg <= UNITY;
        end else if (state_reg == ST_DIV && div_done) begin
            target_reg <= GAIN_W'(div_q);
        end

        // Attack when the gain falls, release otherwise
        if (state_reg == ST_COEF) begin
            coef_reg <= (target_reg < gain_reg) ? attack_reg : release_reg;
        end

        // Shared multiplier, registered
        prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);

        // Smoother accumulation starts with the rounding half
        if (state_reg == ST_MUL_G) begin
            acc_reg <= ACC_W'(prod_reg) + ACC_W'(COEF_HALF);
        end

        // Scaled channels
        if (state_reg == ST_MUL_R) begin
            res_l_reg <= round_sat(prod_reg, left_reg[SAMPLE_W-1]);
        end
        if (state_reg == ST_FIN) begin
            res_r_reg <= round_sat(prod_reg, right_reg[SAMPLE_W-1]);
        end

        // Output register
        if (out_load) begin
            m_left_reg  <= res_l_reg;
            m_right_reg <= res_r_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_left_out  = m_left_reg;
    assign m_right_out = m_right_reg;

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the stereo peak limiter: gain tracker, drivers and checks.
module tb_top
    import spl_pkg::*;
();

    localparam int FRAC        = 16;
    localparam int DRAIN       = 40;    // comfortably outlasts an item that waits on the divider
    localparam int STALL_LIMIT = 4000;
    localparam int SEGMENTS    = 27;
    localparam int SEG_ITEMS   = 50;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
    } limited_pair_t;

    // Tracks the smoothed gain and holds the limited pairs still owed by the block
    class limiter_predictor;
        localparam longint UNITY     = longint'(1) << FRAC;
        localparam longint COEF_UNIT = longint'(1) << COEF_BITS;

        bit            en;
        longint        thr;
        longint        atk;
        longint        rel;
        longint        gain;
        limited_pair_t expected_pairs[$];
        int            errors;

        function new();
            en     = 1'b0;
            thr    = 32767;
            atk    = 0;
            rel    = 0;
            gain   = UNITY;
            errors = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_ENABLE: begin
                    en = val[0];
                    if (!en)
                        gain = UNITY;
                end
                CFG_THRESH:  thr = val[THR_W-1:0];
                CFG_ATTACK:  atk = val;
                CFG_RELEASE: rel = val;
                default: ;
            endcase
        endfunction

        function longint magnitude(logic signed [SAMPLE_W-1:0] x);
            longint sx;
            sx = x;
            return (sx < 0) ? -sx : sx;
        endfunction

        // Sample times gain, rounded half away from zero, saturated to 16 bits
        function logic [SAMPLE_W-1:0] scale(logic signed [SAMPLE_W-1:0] x);
            longint q;
            q = (magnitude(x) * gain + (longint'(1) << (FRAC - 1))) >> FRAC;
            if (x < 0) begin
                if (q > 32768)
                    q = 32768;
                return SAMPLE_W'(65536 - q);
            end
            if (q > 32767)
                q = 32767;
            return SAMPLE_W'(q);
        endfunction

        function void note_input(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r);
            limited_pair_t res;
            longint        pk;
            longint        tgt;
            longint        c;
            if (!en) begin
                gain          = UNITY;
                res.left_out  = l;
                res.right_out = r;
            end else begin
                pk = magnitude(l);
                if (magnitude(r) > pk)
                    pk = magnitude(r);
                tgt = UNITY;
                if (pk > thr)
                    tgt = (thr << FRAC) / pk;
                // attack when the gain has to fall, release otherwise
                c    = (tgt < gain) ? atk : rel;
                gain = ((COEF_UNIT - c) * tgt + c * gain + COEF_UNIT / 2) >> COEF_BITS;
                res.left_out  = scale(l);
                res.right_out = scale(r);
            end
            expected_pairs.push_back(res);
        endfunction

        function void check_output(logic signed [SAMPLE_W-1:0] l,
                                   logic signed [SAMPLE_W-1:0] r);
            limited_pair_t exp_pair;
            if (expected_pairs.size() == 0) begin
                $error("unexpected result transfer: left_out %0d right_out %0d", l, r);
                errors++;
                return;
            end
            exp_pair = expected_pairs.pop_front();
            if (exp_pair.left_out !== l) begin
                $error("left_out: expected %0d, actual %0d", exp_pair.left_out, l);
                errors++;
            end
            if (exp_pair.right_out !== r) begin
                $error("right_out: expected %0d, actual %0d", exp_pair.right_out, r);
                errors++;
            end
        endfunction

        function int pending();
            return expected_pairs.size();
        endfunction
    endclass

    logic                       aclk        = 1'b0;
    logic                       aresetn     = 1'b0;
    logic                       s_valid     = 1'b0;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_left_in   = '0;
    logic signed [SAMPLE_W-1:0] s_right_in  = '0;
    logic                       m_valid;
    logic                       m_ready     = 1'b0;
    logic signed [SAMPLE_W-1:0] m_left_out;
    logic signed [SAMPLE_W-1:0] m_right_out;
    logic                       cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index   = '0;
    logic [CFG_W-1:0]           cfg_wdata   = '0;

    limiter_predictor sb = new();
    int               src_pct  = 0;
    int               sink_pct = 0;
    int               stall_cnt = 0;

    stereo_peak_limiter #(
        .FRAC_BITS (FRAC)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_left_in   (s_left_in),
        .s_right_in  (s_right_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_left_out  (m_left_out),
        .m_right_out (m_right_out),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_pct);
    end

    // Transfer monitors on both channels
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            sb.note_input(s_left_in, s_right_in);
        if (aresetn && m_valid && m_ready)
            sb.check_output(m_left_out, m_right_out);
    end

    // Watchdog: too long without any transfer
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Present one stereo pair, with an occasional gap before it
    task automatic send_pair(input logic [SAMPLE_W-1:0] l, input logic [SAMPLE_W-1:0] r);
        int gap;
        if ($urandom_range(99) < src_pct) begin
            gap = $urandom_range(1, 40);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_left_in  <= l;
        s_right_in <= r;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop valid, collect every owed result, then let the sequencer go quiet
    task automatic settle();
        s_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
    endtask

    // Register writes come in batches; end_writes lowers the strobe afterwards
    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.write_reg(idx, val);
    endtask

    task automatic end_writes();
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic run_directed();
        // pass-through at reset settings, field extremes
        send_pair(16'h8000, 16'h7FFF);
        send_pair(16'h0000, 16'hFFFF);
        send_pair(16'h5A5A, 16'hA5A5);
        settle();
        // limiting on; stray upper bits of the enable data are ignored
        write_reg(CFG_THRESH, 16'd16384);
        write_reg(CFG_ATTACK, 16'h8000);
        write_reg(CFG_RELEASE, 16'hF000);
        write_reg(CFG_ENABLE, 16'hFFFF);
        end_writes();
        send_pair(16'h8000, 16'h8000);
        send_pair(16'h7FFF, 16'h0000);
        send_pair(16'h0000, 16'h8001);
        send_pair(16'd100, 16'hFF9C);
        send_pair(16'h0000, 16'h0000);
        send_pair(16'h8000, 16'h7FFF);
        send_pair(16'd16384, 16'd16385);
        settle();
        // lowest nonzero ceiling, written with bit 15 set so the masking is seen
        write_reg(CFG_THRESH, 16'h8001);
        end_writes();
        send_pair(16'h0000, 16'h0000);
        send_pair(16'h0001, 16'hFFFF);
        send_pair(16'h0002, 16'hFFFD);
        settle();
        // zero ceiling: any nonzero peak drives the target to nothing
        write_reg(CFG_THRESH, 16'h8000);
        end_writes();
        send_pair(16'h0000, 16'h0000);
        send_pair(16'h0001, 16'h0000);
        send_pair(16'h8000, 16'h0005);
        settle();
        // instant attack, slowest possible release
        write_reg(CFG_THRESH, 16'd1000);
        write_reg(CFG_ATTACK, 16'h0000);
        write_reg(CFG_RELEASE, 16'hFFFF);
        end_writes();
        send_pair(16'h7FFF, 16'h0000);
        send_pair(16'd10, 16'd10);
        send_pair(16'h8000, 16'h0000);
        settle();
        // disabling snaps the gain to unity; re-enabling starts transparent
        write_reg(CFG_ENABLE, 16'hFFFE);
        end_writes();
        send_pair(16'h7FFF, 16'h8000);
        settle();
        write_reg(CFG_ENABLE, 16'h0001);
        end_writes();
        send_pair(16'd20000, 16'hB1E0);
        send_pair(16'd500, 16'hFE0C);
        settle();
    endtask

    function automatic logic [CFG_W-1:0] pick_coef();
        case ($urandom_range(5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2, 3:    return CFG_W'($urandom_range(60000, 65535));
            default: return CFG_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_thresh();
        logic [CFG_W-1:0] v;
        case ($urandom_range(19))
            0:       v = 16'd0;
            1, 2:    v = 16'd1;
            3, 4:    v = 16'd32767;
            5, 6, 7: v = CFG_W'($urandom_range(1, 64));
            default: v = CFG_W'($urandom_range(1, 32767));
        endcase
        v[15] = 1'($urandom_range(1));
        return v;
    endfunction

    // Signed sample within +/- span, clipped to the 16-bit range
    function automatic logic [SAMPLE_W-1:0] pick_sample(int span);
        int v;
        v = int'($urandom_range(2 * span)) - span;
        if (v > 32767)
            v = 32767;
        return SAMPLE_W'(v);
    endfunction

    function automatic int pick_level();
        int t;
        t = int'(sb.thr);
        case ($urandom_range(4))
            0:       return 64;
            1:       return (t + t / 4 + 2 > 32768) ? 32768 : t + t / 4 + 2;
            2:       return (2 * t + 2 > 32768) ? 32768 : 2 * t + 2;
            default: return 32768;
        endcase
    endfunction

    task automatic run_segment();
        logic [CFG_W-1:0] en_val;
        int               level;
        en_val    = CFG_W'($urandom);
        en_val[0] = ($urandom_range(9) != 0);
        write_reg(CFG_THRESH, pick_thresh());
        write_reg(CFG_ATTACK, pick_coef());
        write_reg(CFG_RELEASE, pick_coef());
        write_reg(CFG_ENABLE, en_val);
        end_writes();
        // bursts of loud and quiet passages move the gain both ways
        level = pick_level();
        for (int i = 0; i < SEG_ITEMS; i++) begin
            if ($urandom_range(99) < 8)
                level = pick_level();
            if ($urandom_range(9) == 0)
                send_pair(SAMPLE_W'($urandom), SAMPLE_W'($urandom));
            else
                send_pair(pick_sample(level), pick_sample(level));
        end
        settle();
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_directed();
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            if (seg < SEGMENTS / 3) begin
                src_pct  = 32;
                sink_pct = 51;
            end else if (seg < 2 * SEGMENTS / 3) begin
                src_pct  = 51;
                sink_pct = 32;
            end else begin
                src_pct  = 0;
                sink_pct = 0;
            end
            run_segment();
        end
        settle();
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
